/* rtl/utf8_lenient_decoder_top_macros.svh */
// Assertion shorthands for the UTF-8 decoder.
// Each takes a label, clock, active-low reset, antecedent and consequent.
`ifndef UTF8_LENIENT_DECODER_TOP_MACROS_SVH
`define UTF8_LENIENT_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define U8LD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("u8ld assertion failed");
`define U8LD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("u8ld assertion failed");
`else
`define U8LD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define U8LD_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* rtl/u8ld_pkg.sv */
`timescale 1ns / 1ps

package u8ld_pkg;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned BUF_DEPTH  = 4;
  localparam logic [20:0] REPL_CP    = 21'h00FFFD;

  // Byte with its class, worked out once on entry
  typedef struct packed {
    logic [7:0] data;
    logic       bad;   // cannot start a sequence
    logic [2:0] need;  // sequence length from this lead (1 when bad)
    logic       cont;  // 10xxxxxx
  } byte_cls_t;

  typedef struct packed {
    byte_cls_t b;
    logic      fin;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_port_t;

  function automatic byte_cls_t classify(logic [7:0] b);
    byte_cls_t c;
    c.data = b;
    c.bad  = 1'b0;
    c.need = 3'd1;
    c.cont = ((b & 8'hC0) == 8'h80);
    priority if (b < 8'h80) begin
      c.need = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      c.need = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      c.need = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      c.need = 3'd4;
    end else begin
      c.bad  = 1'b1;
      c.need = 3'd1;
    end
    return c;
  endfunction

  function automatic logic [20:0] decode(logic [7:0] b0, logic [7:0] b1,
                                         logic [7:0] b2, logic [7:0] b3,
                                         logic [2:0] need);
    logic [20:0] cp;
    unique case (need)
      3'd1:    cp = {13'd0, b0};
      3'd2:    cp = {10'd0, b0[4:0], b1[5:0]};
      3'd3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
      default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    endcase
    return cp;
  endfunction

endpackage

/* rtl/u8ld_in_if.sv */
`timescale 1ns / 1ps

interface u8ld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       final_byte;

  modport source (output valid, output in_byte, output final_byte, input ready);
  modport sink   (input valid, input in_byte, input final_byte, output ready);
endinterface

/* rtl/u8ld_out_if.sv */
`timescale 1ns / 1ps

interface u8ld_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        run_last;
  logic        text_end;

  modport source (output valid, output code_point, output run_last, output text_end,
                  input ready);
  modport sink   (input valid, input code_point, input run_last, input text_end,
                  output ready);
endinterface

/* rtl/u8ld_front.sv */
`timescale 1ns / 1ps
`include "utf8_lenient_decoder_top_macros.svh"

module u8ld_front #(
  parameter int unsigned FIFO_DEPTH = u8ld_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  u8ld_in_if.sink            in_if,
  output u8ld_pkg::q_port_t  q_out,
  input  logic               q_pop
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  u8ld_pkg::item_t mem_r [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            push;
  u8ld_pkg::item_t push_item;

  assign in_if.ready = (cnt_r != CW'(FIFO_DEPTH));
  assign push        = in_if.valid && in_if.ready;

  always_comb begin
    push_item.b   = u8ld_pkg::classify(in_if.in_byte);
    push_item.fin = in_if.final_byte;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_out.valid = (cnt_r != '0);
  assign q_out.item  = mem_r[rd_ptr_r];

  `U8LD_ASSERT_IMP(a_fifo_bound, clk, rst_n, 1'b1, cnt_r <= CW'(FIFO_DEPTH))
  `U8LD_ASSERT_IMP(a_pop_nonempty, clk, rst_n, q_pop, cnt_r != '0)
  `U8LD_ASSERT_NXT(a_push_grows, clk, rst_n, push && !q_pop, cnt_r == $past(cnt_r) + 1'b1)

endmodule

/* rtl/u8ld_back.sv */
`timescale 1ns / 1ps
`include "utf8_lenient_decoder_top_macros.svh"

module u8ld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  u8ld_pkg::q_port_t q_in,
  output logic              q_pop,
  u8ld_out_if.source        out_if
);

  localparam int unsigned BD = u8ld_pkg::BUF_DEPTH;

  // pending sequence bytes
  u8ld_pkg::byte_cls_t buf_r [BD];
  u8ld_pkg::byte_cls_t buf_nxt [BD];
  logic [2:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                fin_r, fin_nxt;

  // working view for this cycle's parse step
  u8ld_pkg::byte_cls_t w [BD];
  u8ld_pkg::byte_cls_t s [BD];
  logic [2:0]          wcnt;
  logic                wfin;
  logic                wvalid;

  logic        incomplete, ok, more, emit, last, te, go, can_load;
  logic        s_incomplete;
  logic [2:0]  consume, rem, sel;
  logic [20:0] res_cp;

  logic        out_valid_r, out_valid_nxt;
  logic [20:0] out_cp_r;
  logic        out_last_r;
  logic        out_te_r;

  always_comb begin
    for (int i = 0; i < BD; i++) begin
      w[i] = buf_r[i];
    end
    wcnt   = cnt_r;
    wfin   = fin_r;
    wvalid = busy_r;
    if (!busy_r) begin
      // append the fresh byte behind what is pending
      wvalid             = q_in.valid;
      wfin               = q_in.item.fin;
      w[cnt_r[1:0]]      = q_in.item.b;
      wcnt               = cnt_r + 3'd1;
    end
  end

  always_comb begin
    sel          = '0;
    incomplete   = !w[0].bad && (w[0].need > wcnt);
    ok           = !w[0].bad && !incomplete
                   && ((w[0].need < 3'd2) || w[1].cont)
                   && ((w[0].need < 3'd3) || w[2].cont)
                   && ((w[0].need < 3'd4) || w[3].cont);
    consume      = ok ? w[0].need : 3'd1;
    rem          = wcnt - consume;
    for (int i = 0; i < BD; i++) begin
      sel = 3'(i) + consume;
      s[i] = (sel < 3'(BD)) ? w[sel[1:0]] : w[i];
    end
    s_incomplete = !s[0].bad && (s[0].need > rem);
    more         = (rem != 3'd0) && (wfin || !s_incomplete);
    emit         = !incomplete || wfin;
    last         = incomplete || !more;
    te           = last && wfin;
    res_cp       = ok ? u8ld_pkg::decode(w[0].data, w[1].data, w[2].data, w[3].data,
                                         w[0].need)
                      : u8ld_pkg::REPL_CP;
    can_load     = !out_valid_r || out_if.ready;
    go           = wvalid && (!emit || can_load);
    q_pop        = go && !busy_r;
  end

  always_comb begin
    for (int i = 0; i < BD; i++) begin
      buf_nxt[i] = buf_r[i];
    end
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    fin_nxt  = fin_r;
    if (go) begin
      if (incomplete) begin
        for (int i = 0; i < BD; i++) begin
          buf_nxt[i] = w[i];
        end
        busy_nxt = 1'b0;
        cnt_nxt  = wfin ? 3'd0 : wcnt;
      end else begin
        for (int i = 0; i < BD; i++) begin
          buf_nxt[i] = s[i];
        end
        busy_nxt = more;
        fin_nxt  = wfin;
        cnt_nxt  = (wfin && !more) ? 3'd0 : rem;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < BD; i++) begin
      buf_r[i] <= buf_nxt[i];
    end
    if (go && emit) begin
      out_cp_r   <= res_cp;
      out_last_r <= last;
      out_te_r   <= te;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.code_point = out_cp_r;
  assign out_if.run_last   = out_last_r;
  assign out_if.text_end   = out_te_r;

  `U8LD_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, cnt_r <= 3'd3)
  `U8LD_ASSERT_IMP(a_busy_has_bytes, clk, rst_n, busy_r, cnt_r != 3'd0)
  `U8LD_ASSERT_NXT(a_end_clears, clk, rst_n, go && emit && te, (cnt_r == 3'd0) && !busy_r)
  `U8LD_ASSERT_IMP(a_end_is_last, clk, rst_n, out_valid_r && out_te_r, out_last_r)

endmodule

/* rtl/utf8_lenient_decoder_top.sv */
`timescale 1ns / 1ps
// Path: an accepted input beat goes into a queue entry, then its first result into
//   the output register. Throughput: one byte per cycle while the output is ready,
//   when a byte gives at most one code point; a byte that releases several results
//   (up to 4) holds the parser; one result per cycle while the output is ready.
// Reset: synchronous, active low; clears queue, pending count and output valid.

module utf8_lenient_decoder_top #(
  parameter int unsigned FIFO_DEPTH = u8ld_pkg::FIFO_DEPTH  // queue entries, 2 to 8
) (
  input  logic       clk,
  input  logic       rst_n,
  u8ld_in_if.sink    in_if,
  u8ld_out_if.source out_if
);

  // Front end: classifies each byte (lead length, continuation, bad lead)
  // and holds it in a short queue so it can take a beat while the back
  // end works through an error burst.
  u8ld_pkg::q_port_t q;
  logic              q_pop;

  u8ld_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .q_out (q),
    .q_pop (q_pop)
  );

  // Back end: appends the byte to the pending sequence and runs one parse
  // step per cycle while the output register can take a beat; each step that ends a
  // sequence or finds an error yields one code point or U+FFFD into that register.
  u8ld_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_in   (q),
    .q_pop  (q_pop),
    .out_if (out_if)
  );

endmodule
